[sv/tkspt_pkg.sv]
// ----------------------------------------------------------------------------
// tkspt_pkg: shared types and constants for the top-k sorted pin table
// Table size, field widths, outcome codes, cell operations and controller
// states used by the cell row and the controller.
// ----------------------------------------------------------------------------
package tkspt_pkg;

    // Table size and derived widths
    localparam int CAPACITY  = 8;
    localparam int ID_W      = 16;
    localparam int CNT_W     = 8;
    localparam int SUM_W     = 10;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int OUTCOME_W = 3;
    localparam int ECOUNT_W  = 4;
    localparam int RANK_W    = 3;

    // Command codes
    localparam logic CMD_PIN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_UPDATED  = 3'd0,
        OC_INSERTED = 3'd1,
        OC_EVICTED  = 3'd2,
        OC_REJECTED = 3'd3,
        OC_CLEARED  = 3'd4
    } t_outcome;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_MARK    = 3'd2,
        OP_EVICT   = 3'd3,
        OP_COMPACT = 3'd4,
        OP_INSERT  = 3'd5
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_WAIT
    } t_state;

    // Slot payload; pre marks an entry that sat ahead of the updated one
    typedef struct packed {
        logic             pre;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
        logic [CNT_W-1:0] cnt_c;
        logic [SUM_W-1:0] sum;
    } t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_entry;

endpackage

[sv/tkspt_cell.sv]
// ----------------------------------------------------------------------------
// tkspt_cell: one slot of the sorted table
// Holds one entry, compares it against the broadcast word and takes its own,
// its left or right neighbour's entry, or the new word, as the operation says.
// ----------------------------------------------------------------------------
module tkspt_cell
    import tkspt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  t_slot    i_item,
    input  t_entry   i_left,
    input  logic     i_left_before,
    input  t_entry   i_right,
    input  logic     i_seen,
    output t_entry   o_entry,
    output logic     o_before,
    output logic     o_seen,
    output logic     o_took_new
);

    logic  r_valid;
    logic  n_valid;
    t_slot r_slot;
    t_slot n_slot;
    logic  w_hit;

    // Id match; ids in the table are unique so at most one cell hits
    assign w_hit  = r_valid && (r_slot.id == i_item.id);
    assign o_seen = i_seen | w_hit;

    // Entry stays ahead of the new word: larger sum, or equal sum and
    // originally ahead of it
    assign o_before = r_valid && ((r_slot.sum > i_item.sum) ||
                                  ((r_slot.sum == i_item.sum) && r_slot.pre));

    assign o_took_new = (i_op == OP_INSERT) && !o_before && i_left_before;

    assign o_entry.valid = r_valid;
    assign o_entry.slot  = r_slot;

    // Next slot contents
    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_MARK: begin
                n_slot.pre = 1'b1;
            end
            OP_EVICT: begin
                // only the last cell sees an empty right neighbour
                n_valid    = i_right.valid;
                n_slot.pre = 1'b1;
            end
            OP_COMPACT: begin
                if (o_seen) begin
                    n_valid    = i_right.valid;
                    n_slot     = i_right.slot;
                    n_slot.pre = 1'b0;
                end else begin
                    n_slot.pre = 1'b1;
                end
            end
            OP_INSERT: begin
                if (o_before) begin
                    n_slot = r_slot;
                end else if (i_left_before) begin
                    n_valid = 1'b1;
                    n_slot  = i_item;
                end else begin
                    n_valid = i_left.valid;
                    n_slot  = i_left.slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

[sv/top_k_sorted_pin_table_unit.sv]
// ----------------------------------------------------------------------------
// top_k_sorted_pin_table_unit: bounded top-k table kept in sorted order
// Row of slot cells plus a small controller for remove and insert passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall, word = cmd, entry_id, count_a..c.
//   Output channel: o_out_valid / i_out_stall, word = outcome, entry_count,
//   rank, evicted_id. Every input word gives exactly one output word.
//   A word is processed in two passes over the cell row: a remove pass
//   (id match, compaction, marking, eviction or clear) and an insert pass
//   (each cell keeps, shifts right or takes the new entry). The word is
//   captured, then the remove and insert states follow, and the result is
//   registered at the end of the insert state; a new word is taken in the
//   insert cycle of the previous one when the output is free.
//   Reset empties the table; the slot contents themselves are not cleared.
//   If the receiver stalls, the result waits in the output register; a
//   second result is parked in a holding register and no further word is
//   taken until the output drains.
// ----------------------------------------------------------------------------
module top_k_sorted_pin_table_unit
    import tkspt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [ID_W-1:0]      i_entry_id,
    input  logic [CNT_W-1:0]     i_count_a,
    input  logic [CNT_W-1:0]     i_count_b,
    input  logic [CNT_W-1:0]     i_count_c,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [ECOUNT_W-1:0]  o_entry_count,
    output logic [RANK_W-1:0]    o_rank,
    output logic [ID_W-1:0]      o_evicted_id
);

    t_state             r_state;
    t_state             n_state;
    logic               r_cmd;
    t_slot              r_item;
    t_outcome           r_outcome;
    logic [ID_W-1:0]    r_evicted;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [OUTCOME_W-1:0] r_o_outcome;
    logic [ECOUNT_W-1:0]  r_o_count;
    logic [RANK_W-1:0]    r_o_rank;
    logic [ID_W-1:0]      r_o_evicted;

    logic [OUTCOME_W-1:0] r_p_outcome;
    logic [ECOUNT_W-1:0]  r_p_count;
    logic [RANK_W-1:0]    r_p_rank;
    logic [ID_W-1:0]      r_p_evicted;

    t_cell_op w_op;
    logic     w_ready;
    logic     w_accept;
    logic     w_out_free;
    logic     w_full;
    logic     w_inserts;
    t_outcome w_rm_outcome;

    t_entry                w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_before;
    logic [CAPACITY-1:0]   w_took_new;
    logic [CAPACITY:0]     w_seen;
    logic [IDX_W-1:0]      w_rank;

    logic [COUNT_W+ECOUNT_W-1:0] w_count_ext;
    logic [IDX_W+RANK_W-1:0]     w_rank_ext;
    logic [ECOUNT_W-1:0]         w_res_count;
    logic [RANK_W-1:0]           w_res_rank;

    // Cell row
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_before;

        if (g == 0) begin : g_first
            assign w_left        = '0;
            assign w_left_before = 1'b1;
        end else begin : g_mid
            assign w_left        = w_entry[g-1];
            assign w_left_before = w_before[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        tkspt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_item       (r_item),
            .i_left       (w_left),
            .i_left_before(w_left_before),
            .i_right      (w_right),
            .i_seen       (w_seen[g]),
            .o_entry      (w_entry[g]),
            .o_before     (w_before[g]),
            .o_seen       (w_seen[g+1]),
            .o_took_new   (w_took_new[g])
        );
    end

    // Remove pass decision
    assign w_full = (r_count == COUNT_W'(CAPACITY));

    always_comb begin
        priority if (r_cmd == CMD_CLEAR) begin
            w_rm_outcome = OC_CLEARED;
        end else if (w_seen[CAPACITY]) begin
            w_rm_outcome = OC_UPDATED;
        end else if (!w_full) begin
            w_rm_outcome = OC_INSERTED;
        end else if (r_item.sum > w_entry[CAPACITY-1].slot.sum) begin
            w_rm_outcome = OC_EVICTED;
        end else begin
            w_rm_outcome = OC_REJECTED;
        end
    end

    assign w_inserts = (r_outcome == OC_UPDATED) || (r_outcome == OC_INSERTED) ||
                       (r_outcome == OC_EVICTED);

    // Handshake helpers
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    // Controller outputs
    always_comb begin
        w_op    = OP_HOLD;
        w_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
            end
            ST_REMOVE: begin
                unique case (w_rm_outcome)
                    OC_CLEARED:  w_op = OP_CLEAR;
                    OC_UPDATED:  w_op = OP_COMPACT;
                    OC_EVICTED:  w_op = OP_EVICT;
                    OC_INSERTED: w_op = OP_MARK;
                    OC_REJECTED: w_op = OP_HOLD;
                    default:     w_op = OP_HOLD;
                endcase
            end
            ST_INSERT: begin
                w_op    = w_inserts ? OP_INSERT : OP_HOLD;
                w_ready = w_out_free;
            end
            ST_WAIT: begin
                w_op = OP_HOLD;
            end
        endcase
    end

    // Controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_REMOVE;
            end
            ST_REMOVE: begin
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                if (!w_out_free) begin
                    n_state = ST_WAIT;
                end else if (w_accept) begin
                    n_state = ST_REMOVE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
        endcase
    end

    // Rank of the new entry from the cell that took it
    always_comb begin
        w_rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_took_new[i]) w_rank = w_rank | IDX_W'(i);
        end
    end

    // Entry count after the insert pass
    assign n_count     = w_inserts ? r_count + COUNT_W'(1) : r_count;
    assign w_count_ext = (COUNT_W + ECOUNT_W)'(n_count);
    assign w_rank_ext  = (IDX_W + RANK_W)'(w_rank);
    assign w_res_count = w_count_ext[ECOUNT_W-1:0];
    assign w_res_rank  = w_rank_ext[RANK_W-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_REMOVE) begin
                unique case (w_rm_outcome)
                    OC_CLEARED:  r_count <= '0;
                    OC_UPDATED:  r_count <= r_count - COUNT_W'(1);
                    OC_EVICTED:  r_count <= r_count - COUNT_W'(1);
                    OC_INSERTED: r_count <= r_count;
                    OC_REJECTED: r_count <= r_count;
                    default:     r_count <= r_count;
                endcase
            end else if (r_state == ST_INSERT) begin
                r_count <= n_count;
            end
        end
    end

    // Output valid
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((r_state == ST_INSERT || r_state == ST_WAIT) && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Word capture and remove pass results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_cmd;
            r_item.pre   <= 1'b0;
            r_item.id    <= i_entry_id;
            r_item.cnt_a <= i_count_a;
            r_item.cnt_b <= i_count_b;
            r_item.cnt_c <= i_count_c;
            r_item.sum   <= SUM_W'(i_count_a) + SUM_W'(i_count_b) + SUM_W'(i_count_c);
        end
        if (r_state == ST_REMOVE) begin
            r_outcome <= w_rm_outcome;
            r_evicted <= (w_rm_outcome == OC_EVICTED) ? w_entry[CAPACITY-1].slot.id : '0;
        end
    end

    // Output and holding registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INSERT) begin
            if (w_out_free) begin
                r_o_outcome <= r_outcome;
                r_o_count   <= w_res_count;
                r_o_rank    <= w_res_rank;
                r_o_evicted <= r_evicted;
            end else begin
                r_p_outcome <= r_outcome;
                r_p_count   <= w_res_count;
                r_p_rank    <= w_res_rank;
                r_p_evicted <= r_evicted;
            end
        end else if (r_state == ST_WAIT && w_out_free) begin
            r_o_outcome <= r_p_outcome;
            r_o_count   <= r_p_count;
            r_o_rank    <= r_p_rank;
            r_o_evicted <= r_p_evicted;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_o_outcome;
    assign o_entry_count = r_o_count;
    assign o_rank        = r_o_rank;
    assign o_evicted_id  = r_o_evicted;

endmodule
